[src/rmq_pkg.sv]
// Shared constants and types for the rotation matrix to quaternion block.
// No dependencies; used by every module of the block but rmq_fifo.
package rmq_pkg;

    // Default word format: signed Q2.14.
    localparam int WORD_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Depth of the queue between the classifier and the arithmetic back end.
    localparam int QUEUE_DEPTH = 4;

    // Component chosen as the largest one.
    typedef enum logic [1:0] {
        PART_W = 2'd0,
        PART_X = 2'd1,
        PART_Y = 2'd2,
        PART_Z = 2'd3
    } part_t;

endpackage

[src/rmq_front.sv]
// Front end: forms the diagonal sums, picks the largest component and the
// three off-diagonal sums or differences it needs. Uses rmq_pkg.
module rmq_front #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [9*WORD_BITS-1:0]     in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [4*WORD_BITS+6:0]     out_data
);

    localparam int W  = WORD_BITS;
    localparam int DW = W + 1;
    localparam int SW = W + 2;

    logic signed [SW-1:0] re [9];
    logic signed [SW-1:0] s_w, s_x, s_y, s_z, big;
    logic signed [SW-1:0] a_f, b_f, c_f, p12_f, p13_f, p23_f;
    logic [DW-1:0]        a_d, b_d, c_d, p12_d, p13_d, p23_d;
    logic [DW-1:0]        l0, l1, l2;
    logic [SW-1:0]        rad;
    logic [SW-1:0]        one_q;
    rmq_pkg::part_t       part;

    logic                                   valid_reg;
    logic [4*W+6:0]                         data_reg;

    // Sign-extend the nine elements.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            re[k] = {{2{in_data[k*W+W-1]}}, in_data[k*W +: W]};
        end
    end

    // Diagonal sums, each 4q^2 - 1 for its component.
    assign s_w = re[0] + re[4] + re[8];
    assign s_x = re[0] - re[4] - re[8];
    assign s_y = re[4] - re[0] - re[8];
    assign s_z = re[8] - re[0] - re[4];

    // Largest sum; a later one wins only when strictly greater.
    always_comb
    begin
        big  = s_w;
        part = rmq_pkg::PART_W;
        if (s_x > big)
        begin
            big  = s_x;
            part = rmq_pkg::PART_X;
        end
        if (s_y > big)
        begin
            big  = s_y;
            part = rmq_pkg::PART_Y;
        end
        if (s_z > big)
        begin
            big  = s_z;
            part = rmq_pkg::PART_Z;
        end
    end

    // The largest sum is never negative, so the radicand is at least one.
    assign one_q = SW'(1) << FRAC_BITS;
    assign rad   = big + one_q;

    // Off-diagonal sums and differences; all fit in one bit more than a word.
    assign a_f   = re[5] - re[7];
    assign b_f   = re[6] - re[2];
    assign c_f   = re[1] - re[3];
    assign p12_f = re[1] + re[3];
    assign p13_f = re[6] + re[2];
    assign p23_f = re[5] + re[7];
    assign a_d   = a_f[DW-1:0];
    assign b_d   = b_f[DW-1:0];
    assign c_d   = c_f[DW-1:0];
    assign p12_d = p12_f[DW-1:0];
    assign p13_d = p13_f[DW-1:0];
    assign p23_d = p23_f[DW-1:0];

    // Lanes hold the three other components in ascending order.
    always_comb
    begin
        unique case (part)
            rmq_pkg::PART_W:
            begin
                l0 = a_d;
                l1 = b_d;
                l2 = c_d;
            end
            rmq_pkg::PART_X:
            begin
                l0 = a_d;
                l1 = p12_d;
                l2 = p13_d;
            end
            rmq_pkg::PART_Y:
            begin
                l0 = b_d;
                l1 = p12_d;
                l2 = p23_d;
            end
            default:
            begin
                l0 = c_d;
                l1 = p13_d;
                l2 = p23_d;
            end
        endcase
    end

    // Output register toward the queue.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= {part, l2, l1, l0, rad};
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[src/rmq_fifo.sv]
// Short register queue between front and back end.
// No package dependencies; DEPTH must be a power of two.
module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/rmq_back.sv]
// Back end: pipelined square root of the radicand, then three pipelined
// restoring dividers, saturation and the output register. Uses rmq_pkg.
module rmq_back #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_pop,
    input  logic [4*WORD_BITS+6:0]         in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [4*WORD_BITS-1:0]         out_q,
    output logic [1:0]                     out_part
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = W + 1;
    localparam int SW = W + 2;
    localparam int RB = (W + F + 3) / 2;
    localparam int SQ = 2 * RB;
    localparam int QB = W + 1;
    localparam int CW = RB + 3 + W;
    localparam int PL = 3 * DW + 2;

    logic adv;

    // Square root stages.
    logic          sq_v [RB+1];
    logic [SQ-1:0] sq_x [RB+1];
    logic [SQ-1:0] sq_r [RB+1];
    logic [PL-1:0] sq_p [RB+1];

    // Divider stages.
    logic          dv_v    [QB+1];
    logic [RB+1:0] dv_den  [QB+1];
    logic [RB-1:0] dv_b    [QB+1];
    logic [1:0]    dv_part [QB+1];
    logic [CW-1:0] dv_rem  [QB+1][3];
    logic [QB-1:0] dv_q    [QB+1][3];
    logic          dv_neg  [QB+1][3];

    logic          out_valid_reg;
    logic [4*W-1:0] out_q_reg;
    logic [1:0]    out_part_reg;

    // The whole back end moves together when the output can take an item.
    assign adv    = !out_valid_reg || out_ready;
    assign in_pop = adv && in_valid;

    // Entry into the root pipeline: radicand scaled by one more fraction step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_x[0] <= SQ'(in_data[SW-1:0]) << F;
            sq_r[0] <= '0;
            sq_p[0] <= in_data[SW +: PL];
        end
    end

    // One result bit of the integer square root per stage.
    for (genvar i = 0; i < RB; i++)
    begin : g_root
        localparam logic [SQ-1:0] ONE_BIT = SQ'(1) << (2 * (RB - 1 - i));
        logic [SQ-1:0] trial;
        logic [SQ-1:0] x_nx, r_nx;

        assign trial = sq_r[i] + ONE_BIT;

        always_comb
        begin
            if (sq_x[i] >= trial)
            begin
                x_nx = sq_x[i] - trial;
                r_nx = (sq_r[i] >> 1) + ONE_BIT;
            end
            else
            begin
                x_nx = sq_x[i];
                r_nx = sq_r[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v[i+1] <= sq_v[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_x[i+1] <= x_nx;
                sq_r[i+1] <= r_nx;
                sq_p[i+1] <= sq_p[i];
            end
        end
    end

    // Round the root, halve it and set up the three numerators.
    logic [RB:0]   r_p1;
    logic [RB-1:0] b_val;
    logic [RB+1:0] den_val;

    assign r_p1    = sq_r[RB][RB:0] + (RB+1)'(1);
    assign b_val   = r_p1[RB:1];
    assign den_val = {b_val, 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v[0] <= sq_v[RB];
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_prep
        logic [DW-1:0] d_in, mag;
        logic          neg;

        assign d_in = sq_p[RB][j*DW +: DW];
        assign neg  = d_in[DW-1];
        assign mag  = neg ? (~d_in + DW'(1)) : d_in;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem[0][j] <= (CW'(mag) << F) + CW'({b_val, 1'b0});
                dv_q[0][j]   <= '0;
                dv_neg[0][j] <= neg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_den[0]  <= den_val;
            dv_b[0]    <= b_val;
            dv_part[0] <= sq_p[RB][3*DW +: 2];
        end
    end

    // One quotient bit per stage in each of the three lanes.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        localparam int K = QB - 1 - s;
        logic [CW-1:0] shifted;

        assign shifted = CW'(dv_den[s]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v[s+1] <= dv_v[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_den[s+1]  <= dv_den[s];
                dv_b[s+1]    <= dv_b[s];
                dv_part[s+1] <= dv_part[s];
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_neg[s+1][j] <= dv_neg[s][j];
                    if (dv_rem[s][j] >= shifted)
                    begin
                        dv_rem[s+1][j] <= dv_rem[s][j] - shifted;
                        dv_q[s+1][j]   <= dv_q[s][j] | (QB'(1) << K);
                    end
                    else
                    begin
                        dv_rem[s+1][j] <= dv_rem[s][j];
                        dv_q[s+1][j]   <= dv_q[s][j];
                    end
                end
            end
        end
    end

    // Saturate to the word range and place the lanes.
    localparam logic [QB-1:0] POS_MAX = QB'((1 << (W - 1)) - 1);
    localparam logic [QB-1:0] NEG_MAX = QB'(1) << (W - 1);
    localparam logic [W-1:0]  WMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN    = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] lane_w [3];
    logic [W-1:0] big_w;
    logic [W-1:0] qv [4];

    for (genvar j = 0; j < 3; j++)
    begin : g_sat
        logic [QB-1:0] qm;
        assign qm = dv_q[QB][j];

        always_comb
        begin
            if (dv_neg[QB][j])
            begin
                lane_w[j] = (qm > NEG_MAX) ? WMIN : (~qm[W-1:0] + W'(1));
            end
            else
            begin
                lane_w[j] = (qm > POS_MAX) ? WMAX : qm[W-1:0];
            end
        end
    end

    assign big_w = (QB'(dv_b[QB]) > POS_MAX) ? WMAX : W'(dv_b[QB]);

    always_comb
    begin
        unique case (rmq_pkg::part_t'(dv_part[QB]))
            rmq_pkg::PART_W:
            begin
                qv[0] = big_w;
                qv[1] = lane_w[0];
                qv[2] = lane_w[1];
                qv[3] = lane_w[2];
            end
            rmq_pkg::PART_X:
            begin
                qv[0] = lane_w[0];
                qv[1] = big_w;
                qv[2] = lane_w[1];
                qv[3] = lane_w[2];
            end
            rmq_pkg::PART_Y:
            begin
                qv[0] = lane_w[0];
                qv[1] = lane_w[1];
                qv[2] = big_w;
                qv[3] = lane_w[2];
            end
            default:
            begin
                qv[0] = lane_w[0];
                qv[1] = lane_w[1];
                qv[2] = lane_w[2];
                qv[3] = big_w;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_v[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_q_reg    <= {qv[3], qv[2], qv[1], qv[0]};
            out_part_reg <= dv_part[QB];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_q     = out_q_reg;
    assign out_part  = out_part_reg;

endmodule

[src/rotation_matrix_to_quaternion.sv]
// Top level of the rotation matrix to quaternion converter.
// Instantiates rmq_front, rmq_fifo and rmq_back; uses rmq_pkg.
//
// Usage:
//   The slave stream takes one 3x3 matrix per item in signed fixed point
//   (WORD_BITS wide, FRAC_BITS fraction bits). The master stream gives the
//   quaternion w, x, y, z in the same format in tdata and the index of the
//   largest component (0 w, 1 x, 2 y, 3 z) in tuser.
//   Throughput is one item per clock while the receiver keeps m_tready high.
//   The square root pipeline gives one root bit per stage and the dividers
//   one quotient bit per stage. The front end classifies the item and
//   writes it into a four-entry queue; the back end stalls as a whole while
//   a result is offered and the receiver holds m_tready low, and the queue
//   keeps the front end taking items until it fills. Reset clears all valid
//   flags; no item is in flight afterwards.
module rotation_matrix_to_quaternion #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // r11, r12, r13, r21, r22, r23, r31, r32, r33 from the lowest bit up
    input  logic [((9*WORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // qw, qx, qy, qz from the lowest bit up
    output logic [((4*WORD_BITS+7)/8)*8-1:0] m_tdata,
    // largest_part
    output logic [1:0] m_tuser
);

    localparam int W   = WORD_BITS;
    localparam int QW  = 4 * W + 7;
    localparam int OB  = ((4 * W + 7) / 8) * 8;

    logic          f_valid, f_ready;
    logic [QW-1:0] f_data;
    logic          q_full, q_empty, q_pop;
    logic [QW-1:0] q_data;
    logic [4*W-1:0] b_q;

    rmq_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[9*W-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    assign f_ready = !q_full;

    rmq_fifo #(
        .WIDTH (QW),
        .DEPTH (rmq_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data (f_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    rmq_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_pop    (q_pop),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_q     (b_q),
        .out_part  (m_tuser)
    );

    assign m_tdata = OB'(b_q);

endmodule

[src/rmq_checker.sv]
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rmq_pkg and the top level's ports.
module rmq_checker #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [((4*WORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic [1:0]             m_tuser
);

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

    logic [W-1:0] chosen;

    assign chosen = m_tdata[m_tuser*W +: W];

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The chosen component is never below one half.
    a_big_half: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !chosen[W-1] && (chosen >= HALF))
        else $error("largest component below one half");

    // Nothing is offered right after reset is released.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_rmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/rotation_matrix_to_quaternion_tb.sv]
// Testbench for the rotation matrix to quaternion converter.
// Predicts each quaternion in the testbench itself and checks every result item.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;

    localparam int FB = 14;
    localparam int LATENCY = 37;

    typedef struct packed {
        logic [15:0] qw;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        rmq_pkg::part_t part;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [143:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;

    quat_t expected_quats[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    rotation_matrix_to_quaternion dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Exact integer square root.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Rounded d * 2^FB / den, halves away from zero, saturated to the word.
    function automatic logic [15:0] quot_sat(input longint d, input longint unsigned den);
        longint unsigned mag;
        longint q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = longint'(((mag << FB) + (den >> 1)) / den);
        if (d < 0)
            q = -q;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Quaternion from a matrix by picking the largest diagonal sum.
    function automatic quat_t matrix_to_quat(input logic [143:0] m);
        longint r[9];
        longint sums[4];
        longint best;
        longint unsigned b;
        longint unsigned den;
        int idx;
        quat_t q;
        for (int i = 0; i < 9; i++)
            r[i] = longint'($signed(m[16*i +: 16]));
        sums[0] = r[0] + r[4] + r[8];
        sums[1] = r[0] - r[4] - r[8];
        sums[2] = -r[0] + r[4] - r[8];
        sums[3] = -r[0] - r[4] + r[8];
        best = sums[0];
        idx = 0;
        for (int k = 1; k < 4; k++)
            if (sums[k] > best)
            begin
                best = sums[k];
                idx = k;
            end
        b = (int_sqrt((longint'(best) + (64'd1 << FB)) << FB) + 1) >> 1;
        den = 4 * b;
        q.part = rmq_pkg::part_t'(idx);
        case (q.part)
            rmq_pkg::PART_W:
            begin
                q.qw = quot_sat(longint'(b), 64'd1 << FB);
                q.qx = quot_sat(r[5] - r[7], den);
                q.qy = quot_sat(r[6] - r[2], den);
                q.qz = quot_sat(r[1] - r[3], den);
            end
            rmq_pkg::PART_X:
            begin
                q.qx = quot_sat(longint'(b), 64'd1 << FB);
                q.qw = quot_sat(r[5] - r[7], den);
                q.qy = quot_sat(r[1] + r[3], den);
                q.qz = quot_sat(r[6] + r[2], den);
            end
            rmq_pkg::PART_Y:
            begin
                q.qy = quot_sat(longint'(b), 64'd1 << FB);
                q.qw = quot_sat(r[6] - r[2], den);
                q.qx = quot_sat(r[1] + r[3], den);
                q.qz = quot_sat(r[5] + r[7], den);
            end
            default:
            begin
                q.qz = quot_sat(longint'(b), 64'd1 << FB);
                q.qw = quot_sat(r[1] - r[3], den);
                q.qx = quot_sat(r[6] + r[2], den);
                q.qy = quot_sat(r[5] + r[7], den);
            end
        endcase
        return q;
    endfunction

    // Sends one matrix item, with random idle cycles ahead of it.
    // Valid stays high afterwards so that items can follow back to back.
    task automatic send_matrix(input logic [143:0] m);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= m;
        expected_quats.push_back(matrix_to_quat(m));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [143:0] pack_matrix(input int v[9]);
        logic [143:0] m;
        for (int i = 0; i < 9; i++)
            m[16*i +: 16] = v[i][15:0];
        return m;
    endfunction

    function automatic logic [143:0] random_matrix();
        logic [143:0] m;
        for (int i = 0; i < 9; i++)
        begin
            case ($urandom_range(3, 0))
                0: m[16*i +: 16] = 16'($urandom_range(16384, 0) - 8192 * $urandom_range(1, 0));
                1: m[16*i +: 16] = $urandom_range(1, 0) ? 16'h8000 : 16'h7fff;
                default: m[16*i +: 16] = 16'($urandom());
            endcase
        end
        return m;
    endfunction

    // Random receiver stalls plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    // Result checker against the oldest expected quaternion.
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_quats.size() == 0)
            begin
                $error("result item with no expectation waiting");
                errors++;
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                if (m_tdata[15:0] !== exp_q.qw)
                begin
                    $error("qw expected %h actual %h", exp_q.qw, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== exp_q.qx)
                begin
                    $error("qx expected %h actual %h", exp_q.qx, m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] !== exp_q.qy)
                begin
                    $error("qy expected %h actual %h", exp_q.qy, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[63:48] !== exp_q.qz)
                begin
                    $error("qz expected %h actual %h", exp_q.qz, m_tdata[63:48]);
                    errors++;
                end
                if (m_tuser !== exp_q.part)
                begin
                    $error("largest_part expected %0d actual %0d", exp_q.part, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Identity, the three half-turns, ties, extremes and a non-rotation.
    task automatic test_directed();
        int v[9];
        v = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(pack_matrix(v));
        v = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(pack_matrix(v));
        v = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
        send_matrix(pack_matrix(v));
        v = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        send_matrix(pack_matrix(v));
        // All sums equal: ties keep w.
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v));
        // Tie between x and y keeps x.
        v = '{0, 100, 0, 100, 0, 0, 0, 0, -16384};
        send_matrix(pack_matrix(v));
        // Rotation about z by 90 degrees.
        v = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};
        send_matrix(pack_matrix(v));
        // Extreme element values to drive saturation.
        v = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(pack_matrix(v));
        v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(pack_matrix(v));
        v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(pack_matrix(v));
        v = '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768};
        send_matrix(pack_matrix(v));
        v = '{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767};
        send_matrix(pack_matrix(v));
        // Off-diagonal values of a single LSB.
        v = '{0, 1, 0, -1, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v));
        send_matrix({144{1'b1}});
        send_matrix({9{16'h5555}});
        send_matrix({9{16'haaaa}});
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_matrix(random_matrix());
        wait_drained();
    endtask

    // Receiver holds off long enough for the queue and pipeline to fill.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 200;
        repeat (80)
            send_matrix(random_matrix());
        wait_drained();
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(450, 0, 0);
        test_random(400, 50, 0);
        test_random(400, 0, 50);
        test_random(400, 10, 10);
        test_backpressure();
        recv_stall_pct = 0;
        repeat (LATENCY + 10)
            @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
